// ----- hdl/dppr_pkg.sv -----
// Shared types and constants for the pulse-height readout parser.
`timescale 1ns / 1ps

package dppr_pkg;

  localparam int CHANNEL_PAIRS = 8;

  localparam logic [3:0] BOARD_TAG  = 4'hA;
  localparam int         TDATA_IN_W  = 40;
  localparam int         TDATA_OUT_W = 160;

  typedef enum logic [9:0] {
    PH_BH0 = 10'b00_0000_0001,
    PH_BH1 = 10'b00_0000_0010,
    PH_BH2 = 10'b00_0000_0100,
    PH_BH3 = 10'b00_0000_1000,
    PH_CH0 = 10'b00_0001_0000,
    PH_CH1 = 10'b00_0010_0000,
    PH_EVH = 10'b00_0100_0000,
    PH_SMP = 10'b00_1000_0000,
    PH_EX2 = 10'b01_0000_0000,
    PH_ENE = 10'b10_0000_0000
  } phase_t;

  typedef enum logic {
    KIND_EVENT   = 1'b0,
    KIND_TAG_ERR = 1'b1
  } kind_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic        packet_start;
    logic [7:0]  module_number;
  } in_item_t;

  // Field order matches m_tdata, highest bits first.
  typedef struct packed {
    logic [30:0] aggregate_size;
    logic [15:0] baseline_quarter;
    logic [4:0]  extras_bits;
    logic        pileup_flag;
    logic [14:0] energy;
    logic [54:0] timestamp;
    logic [22:0] event_counter;
    logic [3:0]  channel;
    logic [7:0]  module_out;
  } evt_t;

  typedef struct packed {
    kind_t result_kind;
    evt_t  data;
  } res_t;

endpackage

// ----- hdl/digitizer_pha_readout_parser.sv -----
// Top level of the pulse-height digitizer readout word parser.
//
//  port group   dir  tdata / tuser                         beat
//  s_*          in   readout word + module / packet start  one 32-bit readout word
//  m_*          out  decoded event fields / result kind    one event or tag error
//  cfg_wr_*     in   timestamp scale, 8 bits               one register write
//
// One word accepted per cycle, sustained while m_tready holds no stall; the parse state updates as each word is taken.
// A result passes through the input register and the output skid register before it shows on m_*.
// The output skid pair absorbs m_tready stalls; s_tready depends on flops only.
// rst is synchronous and clears all parse state; timestamp scale resets to 2.
`timescale 1ns / 1ps

module digitizer_pha_readout_parser (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [7:0]                          cfg_wr_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // data_word[31:0], module_number[39:32]
  input  logic [dppr_pkg::TDATA_IN_W-1:0]     s_tdata,
  // packet_start
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // module_out[7:0], channel[11:8], event_counter[34:12], timestamp[89:35],
  // energy[104:90], pileup_flag[105], extras_bits[110:106],
  // baseline_quarter[126:111], aggregate_size[157:127], zero[159:158]
  output logic [dppr_pkg::TDATA_OUT_W-1:0]    m_tdata,
  // result_kind
  output logic                                m_tuser
);
  import dppr_pkg::*;

  in_item_t s_item;
  in_item_t q_item;
  logic     q_valid;
  logic     q_take;
  logic     res_ready;
  logic     res_valid;
  res_t     res_item;
  res_t     out_item;

  assign s_item.data_word     = s_tdata[31:0];
  assign s_item.module_number = s_tdata[39:32];
  assign s_item.packet_start  = s_tuser;

  dppr_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_item  (s_item),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take)
  );

  dppr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (q_valid),
    .in_item     (q_item),
    .in_take     (q_take),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res_item    (res_item)
  );

  dppr_out_skid u_out_skid (
    .clk      (clk),
    .rst      (rst),
    .up_valid (res_valid),
    .up_ready (res_ready),
    .up_item  (res_item),
    .dn_valid (m_tvalid),
    .dn_ready (m_tready),
    .dn_item  (out_item)
  );

  assign m_tdata = {2'b00, out_item.data};
  assign m_tuser = out_item.result_kind;

endmodule

// ----- hdl/dppr_in_reg.sv -----
// Input register slice holding one readout beat for the parser.
`timescale 1ns / 1ps

module dppr_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_valid,
  output logic               s_ready,
  input  dppr_pkg::in_item_t s_item,
  output logic               q_valid,
  output dppr_pkg::in_item_t q_item,
  input  logic               q_take
);
  import dppr_pkg::*;

  logic full;

  assign s_ready = !full || q_take;
  assign q_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_valid && s_ready) begin
      full <= 1'b1;
    end else if (q_take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      q_item <= s_item;
    end
  end

endmodule

// ----- hdl/dppr_parser.sv -----
// Parse state machine: one readout word per cycle while the output skid can accept, emits events and tag errors.
`timescale 1ns / 1ps

module dppr_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  input  dppr_pkg::in_item_t in_item,
  output logic               in_take,
  input  logic               res_ready,
  output logic               res_valid,
  output dppr_pkg::res_t     res_item
);
  import dppr_pkg::*;

  // {found, index} of the lowest set mask bit at or above first
  function automatic logic [3:0] find_pair(input logic [7:0] mask, input logic [3:0] first);
    logic       found;
    logic [2:0] idx;
    found = 1'b0;
    idx   = 3'd0;
    for (int i = CHANNEL_PAIRS - 1; i >= 0; i--) begin
      if (mask[i] && (4'(i) >= first)) begin
        found = 1'b1;
        idx   = 3'(i);
      end
    end
    return {found, idx};
  endfunction

  logic [7:0]  timestamp_scale;
  phase_t      phase, phase_next;
  logic [7:0]  pair_mask, pair_mask_next;
  logic [2:0]  pair_index, pair_index_next;
  logic [22:0] board_counter, board_counter_next;
  logic [17:0] sample_words, sample_words_next;
  logic [30:0] words_remaining, words_remaining_next;
  logic [17:0] sample_countdown, sample_countdown_next;
  logic [3:0]  current_channel, current_channel_next;
  logic [30:0] time_tag_low, time_tag_low_next;
  logic [31:0] extras_word, extras_word_next;
  logic [7:0]  held_module, held_module_next;
  logic [30:0] held_agg_size, held_agg_size_next;

  phase_t      phase_eff;
  logic [31:0] w;
  logic [30:0] agg_wr;
  logic [17:0] agg_swords;
  logic [17:0] agg_evlen;
  logic        agg_fit;
  logic [3:0]  first_pair;
  logic [3:0]  later_pair;
  logic [17:0] cnt_dec;
  logic [46:0] ts_raw;
  logic [54:0] ts_scaled;
  logic        emit;
  res_t        res;

  assign in_take   = in_valid && res_ready;
  assign res_valid = in_take && emit;
  assign res_item  = res;
  assign w         = in_item.data_word;
  assign phase_eff = in_item.packet_start ? PH_BH0 : phase;

  assign ts_raw    = {extras_word[31:16], time_tag_low};
  assign ts_scaled = {8'd0, ts_raw} * {47'd0, timestamp_scale};
  assign cnt_dec   = sample_countdown - 18'd1;

  // Aggregate header words use the freshly decoded size fields
  assign agg_wr     = (phase_eff == PH_CH1) ?
                      ((held_agg_size >= 31'd2) ? held_agg_size - 31'd2 : 31'd0) :
                      words_remaining;
  assign agg_swords = (phase_eff == PH_CH1) ? {w[15:0], 2'b00} : sample_words;
  assign agg_evlen  = agg_swords + 18'd3;
  assign agg_fit    = agg_wr >= {13'd0, agg_evlen};
  assign first_pair = find_pair(pair_mask, 4'd0);
  assign later_pair = find_pair(pair_mask, {1'b0, pair_index} + 4'd1);

  always_comb begin
    phase_next            = phase_eff;
    pair_mask_next        = pair_mask;
    pair_index_next       = pair_index;
    board_counter_next    = board_counter;
    sample_words_next     = sample_words;
    words_remaining_next  = words_remaining;
    sample_countdown_next = sample_countdown;
    current_channel_next  = current_channel;
    time_tag_low_next     = time_tag_low;
    extras_word_next      = extras_word;
    held_module_next      = held_module;
    held_agg_size_next    = held_agg_size;
    emit                  = 1'b0;
    res                   = '0;

    case (phase_eff)
      PH_BH0: begin
        held_module_next = in_item.module_number;
        phase_next       = PH_BH1;
        if (w[31:28] != BOARD_TAG) begin
          emit                = 1'b1;
          res.result_kind     = KIND_TAG_ERR;
          res.data.module_out = in_item.module_number;
        end
      end
      PH_BH1: begin
        pair_mask_next = w[7:0];
        phase_next     = PH_BH2;
      end
      PH_BH2: begin
        board_counter_next = w[22:0];
        phase_next         = PH_BH3;
      end
      PH_BH3: begin
        if (first_pair[3]) begin
          pair_index_next = first_pair[2:0];
          phase_next      = PH_CH0;
        end else begin
          phase_next = PH_BH0;
        end
      end
      PH_CH0: begin
        held_agg_size_next = w[30:0];
        phase_next         = PH_CH1;
      end
      PH_EVH: begin
        current_channel_next  = {pair_index, w[31]};
        time_tag_low_next     = w[30:0];
        words_remaining_next  = words_remaining - {13'd0, agg_evlen};
        sample_countdown_next = sample_words;
        phase_next            = (sample_words != 18'd0) ? PH_SMP : PH_EX2;
      end
      PH_SMP: begin
        sample_countdown_next = cnt_dec;
        if (cnt_dec == 18'd0) begin
          phase_next = PH_EX2;
        end
      end
      PH_EX2: begin
        extras_word_next = w;
        phase_next       = PH_ENE;
      end
      default: begin
        // PH_CH1 and PH_ENE both end an aggregate step
        if (phase_eff == PH_CH1) begin
          sample_words_next    = agg_swords;
          words_remaining_next = agg_wr;
        end else begin
          emit                      = 1'b1;
          res.result_kind           = KIND_EVENT;
          res.data.module_out       = held_module;
          res.data.channel          = current_channel;
          res.data.event_counter    = board_counter;
          res.data.timestamp        = ts_scaled;
          res.data.energy           = w[14:0];
          res.data.pileup_flag      = w[15];
          res.data.extras_bits      = w[20:16];
          res.data.baseline_quarter = extras_word[15:0];
          res.data.aggregate_size   = held_agg_size;
        end
        if (agg_fit) begin
          phase_next = PH_EVH;
        end else if (later_pair[3]) begin
          pair_index_next = later_pair[2:0];
          phase_next      = PH_CH0;
        end else begin
          phase_next = PH_BH0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timestamp_scale <= 8'd2;
    end else if (cfg_wr_en) begin
      timestamp_scale <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_BH0;
      pair_mask        <= '0;
      pair_index       <= '0;
      board_counter    <= '0;
      sample_words     <= '0;
      words_remaining  <= '0;
      sample_countdown <= '0;
      current_channel  <= '0;
      time_tag_low     <= '0;
      extras_word      <= '0;
      held_module      <= '0;
      held_agg_size    <= '0;
    end else if (in_take) begin
      phase            <= phase_next;
      pair_mask        <= pair_mask_next;
      pair_index       <= pair_index_next;
      board_counter    <= board_counter_next;
      sample_words     <= sample_words_next;
      words_remaining  <= words_remaining_next;
      sample_countdown <= sample_countdown_next;
      current_channel  <= current_channel_next;
      time_tag_low     <= time_tag_low_next;
      extras_word      <= extras_word_next;
      held_module      <= held_module_next;
      held_agg_size    <= held_agg_size_next;
    end
  end

endmodule

// ----- hdl/dppr_out_skid.sv -----
// Two-entry output skid register; upstream ready comes from a flop only.
`timescale 1ns / 1ps

module dppr_out_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  dppr_pkg::res_t up_item,
  output logic           dn_valid,
  input  logic           dn_ready,
  output dppr_pkg::res_t dn_item
);
  import dppr_pkg::*;

  logic main_v;
  logic skid_v;
  res_t main_q;
  res_t skid_q;

  assign up_ready = !skid_v;
  assign dn_valid = main_v;
  assign dn_item  = main_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (dn_ready) begin
        skid_v <= 1'b0;
      end
    end else if (up_valid) begin
      if (!main_v || dn_ready) begin
        main_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (dn_ready) begin
      main_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (dn_ready) begin
        main_q <= skid_q;
      end
    end else if (up_valid) begin
      if (!main_v || dn_ready) begin
        main_q <= up_item;
      end else begin
        skid_q <= up_item;
      end
    end
  end

endmodule

// ----- hdl/dppr_checker.sv -----
// Port-level checks for the readout parser, bound to the top level.
`timescale 1ns / 1ps

module dppr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [159:0] m_tdata,
  input logic         m_tuser
);

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a tag error carries only the module number
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[159:8] == '0))
    else $error("tag error beat carries event fields");

  // a fresh result needs a word accepted before it, through the input and output registers
  a_rise_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result appeared without a source word");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

endmodule

bind digitizer_pha_readout_parser dppr_checker u_dppr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
